@@ hw/rtl/jeti_pkg.sv @@
package jeti_pkg;

  // Iteration count / limit register width and its reset value
  localparam int unsigned LIMIT_W = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

  // Register index, taken from the upper address bits
  typedef enum logic [1:0] {
    REG_CONST_REAL = 2'd0,
    REG_CONST_IMAG = 2'd1,
    REG_ITER_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } state_e;

  // controller -> datapath / output stage
  typedef struct packed {
    logic load;   // take a new start value, clear the count
    logic mul;    // register z*z products
    logic step;   // write back z^2 + c, bump the count
    logic push;   // hand the count to the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish; // escaped or limit reached
  } dp_status_t;

endpackage

@@ hw/rtl/jeti_ctrl.sv @@
module jeti_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   out_free_i,
  input  jeti_pkg::dp_status_t   status_i,
  output jeti_pkg::ctrl_cmd_t    cmd_o
);
  import jeti_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!status_i.finish) begin
          state_d = ST_MUL;
        end else if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      ST_UPD: begin
        cmd_o.step = !status_i.finish;
        cmd_o.push = status_i.finish && out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/jeti_dp.sv @@
module jeti_dp #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 28
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  jeti_pkg::ctrl_cmd_t                  cmd_i,
  input  logic signed [COORD_WIDTH-1:0]        start_real_i,
  input  logic signed [COORD_WIDTH-1:0]        start_imag_i,
  input  logic signed [COORD_WIDTH-3:0]        const_real_i,
  input  logic signed [COORD_WIDTH-3:0]        const_imag_i,
  input  logic [jeti_pkg::LIMIT_W-1:0]         limit_i,
  output jeti_pkg::dp_status_t                 status_o,
  output logic [jeti_pkg::LIMIT_W-1:0]         count_o
);
  import jeti_pkg::*;

  localparam int unsigned PW = 2 * COORD_WIDTH;
  // 4.0 with 2*FRAC_BITS fraction bits
  localparam logic [PW-1:0] FOUR = PW'(1) << (2 * FRAC_BITS + 2);

  logic signed [COORD_WIDTH-1:0] z_re_q, z_im_q;
  logic signed [PW-1:0]          sq_re_q, sq_im_q, cross_q;
  logic [LIMIT_W-1:0]            count_q;

  logic [PW-1:0]                 mag_sum;
  logic signed [PW-1:0]          diff, diff_sh, cross_sh;
  logic signed [COORD_WIDTH-1:0] c_re_ext, c_im_ext;
  logic signed [COORD_WIDTH-1:0] z_re_d, z_im_d;
  logic                          escape, lim_hit;

  // squares are non-negative, so their sum fits unsigned
  assign mag_sum = $unsigned(sq_re_q) + $unsigned(sq_im_q);
  assign escape  = mag_sum > FOUR;
  assign lim_hit = !(count_q < limit_i);

  // floor back to FRAC_BITS; 2xy folds the doubling into the shift
  assign diff     = sq_re_q - sq_im_q;
  assign diff_sh  = diff >>> FRAC_BITS;
  assign cross_sh = cross_q >>> (FRAC_BITS - 1);

  assign c_re_ext = {{2{const_real_i[COORD_WIDTH-3]}}, const_real_i};
  assign c_im_ext = {{2{const_imag_i[COORD_WIDTH-3]}}, const_imag_i};
  assign z_re_d   = diff_sh[COORD_WIDTH-1:0] + c_re_ext;
  assign z_im_d   = cross_sh[COORD_WIDTH-1:0] + c_im_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      z_re_q <= start_real_i;
      z_im_q <= start_imag_i;
    end else if (cmd_i.step) begin
      z_re_q <= z_re_d;
      z_im_q <= z_im_d;
    end
    if (cmd_i.mul) begin
      sq_re_q <= z_re_q * z_re_q;
      sq_im_q <= z_im_q * z_im_q;
      cross_q <= z_re_q * z_im_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= '0;
    end else if (cmd_i.step) begin
      count_q <= count_q + LIMIT_W'(1);
    end
  end

  assign status_o.finish = escape || lim_hit;
  assign count_o         = count_q;

endmodule

@@ hw/rtl/julia_escape_time_iterator.sv @@
// Julia set escape-time iterator.
// Input channel: start_real_i / start_imag_i give the start value z in signed
// fixed point (FRAC_BITS fraction bits). A request is taken on a clock edge
// with in_valid_i high and in_stall_o low. The block works on one pixel at a
// time and stalls the input while it iterates.
// Each iteration runs on one complex-square unit: state ST_MUL forms x*x,
// y*y and x*y into product registers, and ST_UPD after it does the |z|^2 > 4
// test, the limit test and the write-back of z^2 + c. When the pixel is done,
// the count moves to the output register once that register is free, and the
// next request is taken after the sequencer is back in idle.
// Output channel: iter_count_o with out_valid_o, taken when out_stall_i is
// low. The output register lets the next pixel be taken and iterated while a
// count still waits; if the receiver stalls past that, the datapath holds its
// finished state until the register frees up.
// Config: APB-style, always ready. const_real, const_imag, iteration_limit at
// index 0..2 (byte address 4*i, or 8*i when the constants exceed 32 bits).
// Write only while idle. Reset: constants 0, limit 100, channels empty.
module julia_escape_time_iterator #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 28,
  parameter int unsigned DATA_W      = (COORD_WIDTH - 2 > 32) ? 64 : 32,
  parameter int unsigned ADDR_W      = (DATA_W == 64) ? 5 : 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]        start_real_i,
  input  logic signed [COORD_WIDTH-1:0]        start_imag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [jeti_pkg::LIMIT_W-1:0]         iter_count_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ADDR_W-1:0]                    paddr,
  input  logic [DATA_W-1:0]                    pwdata,
  output logic [DATA_W-1:0]                    prdata,
  output logic                                 pready
);
  import jeti_pkg::*;

  // config registers
  logic signed [COORD_WIDTH-3:0] const_real_q, const_imag_q;
  logic [LIMIT_W-1:0]            limit_q;
  reg_idx_e                      reg_idx;
  logic                          cfg_wr;

  // output register
  logic                          out_valid_q;
  logic [LIMIT_W-1:0]            iter_count_q;
  logic                          out_free;

  ctrl_cmd_t                     cmd;
  dp_status_t                    status;
  logic [LIMIT_W-1:0]            dp_count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:ADDR_W-2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      const_real_q <= '0;
      const_imag_q <= '0;
      limit_q      <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CONST_REAL: const_real_q <= pwdata[COORD_WIDTH-3:0];
        REG_CONST_IMAG: const_imag_q <= pwdata[COORD_WIDTH-3:0];
        REG_ITER_LIMIT: limit_q      <= pwdata[LIMIT_W-1:0];
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CONST_REAL: prdata = DATA_W'($unsigned(const_real_q));
      REG_CONST_IMAG: prdata = DATA_W'($unsigned(const_imag_q));
      REG_ITER_LIMIT: prdata = DATA_W'(limit_q);
      default:        prdata = '0;
    endcase
  end

  // sequencer
  jeti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // z registers, complex-square unit, count
  jeti_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .start_real_i (start_real_i),
    .start_imag_i (start_imag_i),
    .const_real_i (const_real_q),
    .const_imag_i (const_imag_q),
    .limit_i      (limit_q),
    .status_o     (status),
    .count_o      (dp_count)
  );

  // output register: free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      iter_count_q <= dp_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign iter_count_o = iter_count_q;

  // a pending result is never overwritten
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_valid_q || !out_stall_i))
    else $error("result pushed over a stalled result");

  // the count handed out never exceeds the limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (dp_count <= limit_q))
    else $error("iteration count above limit");

  // once a request is taken, the sequencer leaves idle and the input is closed
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input reopened right after a request");

  // a push and a load never coincide
  a_push_not_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.push && cmd.load))
    else $error("push and load in the same cycle");

endmodule
